@@ sv/sfp_pkg.sv @@
`default_nettype none

package sfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes
  localparam logic OP_FEED    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_MORE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_CK_ERR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd2;

  localparam logic [LIMIT_W-1:0] STORE_LIMIT_RST = 17'h10000;
  localparam logic [BYTE_W-1:0]  FIRST_SYNC_RST  = 8'hB5;
  localparam logic [BYTE_W-1:0]  SECOND_SYNC_RST = 8'h62;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_t;

endpackage

`default_nettype wire

@@ sv/sfp_if.sv @@
`default_nettype none

interface sfp_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [sfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface sfp_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfp_pkg::STAT_W-1:0] status;
  logic [sfp_pkg::BYTE_W-1:0] frame_class;
  logic [sfp_pkg::BYTE_W-1:0] frame_id;
  logic [sfp_pkg::LEN_W-1:0]  frame_length;
  logic                       payload_valid;
  logic [sfp_pkg::LEN_W-1:0]  payload_index;
  logic [sfp_pkg::BYTE_W-1:0] payload_byte;

  modport source (output valid, output status, output frame_class, output frame_id,
                  output frame_length, output payload_valid, output payload_index,
                  output payload_byte, input ready);
  modport sink   (input valid, input status, input frame_class, input frame_id,
                  input frame_length, input payload_valid, input payload_index,
                  input payload_byte, output ready);
endinterface

`default_nettype wire

@@ sv/sync_frame_parser_fletcher8_unit.sv @@
// Channel | Direction | Handshake   | Payload
// in_ch   | sink      | valid/ready | operation, rx_byte
// out_ch  | source    | valid/ready | status, frame_class, frame_id, frame_length,
//         |           |             | payload_valid, payload_index, payload_byte
// cfg     | write     | cfg_we      | cfg_index, cfg_wdata
//
// One byte is taken per cycle unless stalled; its result appears in the output
// register in the cycle after the transfer. The parser state and both sums update
// in that same cycle, so the next byte may follow at once. in_ch.ready is low only
// while a result is held and out_ch.ready is low. Synchronous active-low reset
// returns the parser to the sync hunt with the sums and held fields cleared.
`default_nettype none

module sync_frame_parser_fletcher8_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  sfp_in_if.sink                             in_ch,
  sfp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [sfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfp_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import sfp_pkg::*;

  logic [LIMIT_W-1:0] store_limit_r;
  logic [BYTE_W-1:0]  first_sync_r;
  logic [BYTE_W-1:0]  second_sync_r;

  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  sum_a_r, sum_a_nxt;
  logic [BYTE_W-1:0]  sum_b_r, sum_b_nxt;
  logic [BYTE_W-1:0]  held_class_r, held_class_nxt;
  logic [BYTE_W-1:0]  held_id_r, held_id_nxt;
  logic [LEN_W-1:0]   held_length_r, held_length_nxt;
  logic [LEN_W-1:0]   payload_count_r, payload_count_nxt;

  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               pv_r, pv_nxt;
  logic [LEN_W-1:0]   pidx_r, pidx_nxt;
  logic [BYTE_W-1:0]  pbyte_r, pbyte_nxt;

  logic               in_fire;
  logic [BYTE_W-1:0]  b;
  logic [BYTE_W-1:0]  add_a;
  logic [BYTE_W-1:0]  add_b;
  logic [LEN_W-1:0]   count_inc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign add_a       = sum_a_r + b;
  assign add_b       = sum_b_r + add_a;
  assign count_inc   = payload_count_r + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_limit_r <= STORE_LIMIT_RST;
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STORE_LIMIT: store_limit_r <= cfg_wdata;
        CFG_FIRST_SYNC:  first_sync_r  <= cfg_wdata[BYTE_W-1:0];
        CFG_SECOND_SYNC: second_sync_r <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    sum_a_nxt         = sum_a_r;
    sum_b_nxt         = sum_b_r;
    held_class_nxt    = held_class_r;
    held_id_nxt       = held_id_r;
    held_length_nxt   = held_length_r;
    payload_count_nxt = payload_count_r;
    status_nxt        = ST_MORE;
    pv_nxt            = 1'b0;
    pidx_nxt          = '0;
    pbyte_nxt         = '0;
    if (in_ch.operation == OP_RESTART) begin
      phase_nxt = PH_SYNC1;
    end else begin
      unique case (phase_r)
        PH_SYNC2: begin
          if (b == second_sync_r) begin
            phase_nxt = PH_CLASS;
            sum_a_nxt = '0;
            sum_b_nxt = '0;
          end else if (b != first_sync_r) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          held_class_nxt = b;
          sum_a_nxt      = add_a;
          sum_b_nxt      = add_b;
          phase_nxt      = PH_ID;
        end
        PH_ID: begin
          held_id_nxt = b;
          sum_a_nxt   = add_a;
          sum_b_nxt   = add_b;
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_length_nxt = {{(LEN_W-BYTE_W){1'b0}}, b};
          sum_a_nxt       = add_a;
          sum_b_nxt       = add_b;
          phase_nxt       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_length_nxt   = {b, held_length_r[BYTE_W-1:0]};
          sum_a_nxt         = add_a;
          sum_b_nxt         = add_b;
          payload_count_nxt = '0;
          phase_nxt = ({b, held_length_r[BYTE_W-1:0]} != '0) ? PH_PAYLOAD : PH_CK_A;
        end
        PH_PAYLOAD: begin
          if ({1'b0, payload_count_r} < store_limit_r) begin
            pv_nxt    = 1'b1;
            pidx_nxt  = payload_count_r;
            pbyte_nxt = b;
          end
          sum_a_nxt         = add_a;
          sum_b_nxt         = add_b;
          payload_count_nxt = count_inc;
          if (count_inc >= held_length_r) begin
            phase_nxt = PH_CK_A;
          end
        end
        PH_CK_A: begin
          if (b == sum_a_r) begin
            phase_nxt = PH_CK_B;
          end else begin
            phase_nxt  = PH_SYNC1;
            status_nxt = ST_CK_ERR;
          end
        end
        PH_CK_B: begin
          phase_nxt  = PH_SYNC1;
          status_nxt = (b == sum_b_r) ? ST_DONE : ST_CK_ERR;
        end
        // Hunt for the first sync byte; unused codes land here as well.
        default: begin
          phase_nxt = (b == first_sync_r) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SYNC1;
      sum_a_r         <= '0;
      sum_b_r         <= '0;
      held_class_r    <= '0;
      held_id_r       <= '0;
      held_length_r   <= '0;
      payload_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r         <= phase_nxt;
        sum_a_r         <= sum_a_nxt;
        sum_b_r         <= sum_b_nxt;
        held_class_r    <= held_class_nxt;
        held_id_r       <= held_id_nxt;
        held_length_r   <= held_length_nxt;
        payload_count_r <= payload_count_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; the held fields are shown as they stand after the byte.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      pv_r     <= pv_nxt;
      pidx_r   <= pidx_nxt;
      pbyte_r  <= pbyte_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.frame_class   = held_class_r;
  assign out_ch.frame_id      = held_id_r;
  assign out_ch.frame_length  = held_length_r;
  assign out_ch.payload_valid = pv_r;
  assign out_ch.payload_index = pidx_r;
  assign out_ch.payload_byte  = pbyte_r;

endmodule

`default_nettype wire

@@ sv/sfp_checker.sv @@
`default_nettype none

module sfp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_operation,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [sfp_pkg::STAT_W-1:0]  out_status,
  input wire logic                        out_payload_valid,
  input wire logic [sfp_pkg::LEN_W-1:0]   out_payload_index,
  input wire logic [sfp_pkg::BYTE_W-1:0]  out_payload_byte
);
  import sfp_pkg::*;

  // The input side is held back only by a result that is waiting to be taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output register");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_MORE || out_status == ST_DONE ||
                   out_status == ST_CK_ERR))
    else $error("undefined status code");

  // A payload byte is never also the end of a frame.
  a_payload_only_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ST_MORE)
    else $error("payload byte reported with a final status");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_index == '0 && out_payload_byte == '0)
    else $error("payload fields not cleared");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_operation == OP_RESTART |=>
      out_valid && out_status == ST_MORE && !out_payload_valid)
    else $error("restart transfer gave a wrong result");

endmodule

bind sync_frame_parser_fletcher8_unit sfp_checker u_sfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_operation      (in_ch.operation),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_payload_valid (out_ch.payload_valid),
  .out_payload_index (out_ch.payload_index),
  .out_payload_byte  (out_ch.payload_byte)
);

`default_nettype wire
